/* sv/dib_pkg.sv */
// ============================================================================
// DIB to RGBA converter package
// Shared types, register indexes and result status codes.
// ============================================================================
package dib_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_PIXEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSION    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAILABLE      = 3'd5;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_HDR_REJECT = 2'd1;
    localparam logic [1:0] ST_TOO_SHORT  = 2'd2;

    localparam logic [15:0] MIN_HEADER_SIZE = 16'd40;
    localparam logic [15:0] BPP_24          = 16'd24;
    localparam logic [15:0] BPP_32          = 16'd32;
    localparam logic [3:0]  COMP_RGB        = 4'd0;
    localparam logic [3:0]  COMP_BITFIELDS  = 4'd3;
    localparam logic [7:0]  OPAQUE_ALPHA    = 8'hFF;

    typedef struct packed {
        logic        [15:0] header_size;
        logic signed [15:0] image_width;
        logic signed [15:0] image_height;
        logic        [15:0] bits_per_pixel;
        logic        [3:0]  compression_kind;
        logic        [31:0] available_bytes;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] width;
        logic [14:0] height;
        logic        rows_reversed;
        logic        bpp32;
        logic [1:0]  pad;
    } t_hdr;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] dest_row;
        logic [14:0] dest_col;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [14:0] out_width;
        logic [14:0] out_height;
        logic        last_pixel;
    } t_pix;

endpackage

/* sv/dib_ifs.sv */
// ============================================================================
// DIB to RGBA converter channels
// Byte input, pixel result and register write channels.
// ============================================================================
interface dib_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface dib_pix_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [14:0] dest_row;
    logic [14:0] dest_col;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [14:0] out_width;
    logic [14:0] out_height;
    logic        last_pixel;

    modport source (output valid, output status, output dest_row, output dest_col,
                    output red, output green, output blue, output alpha,
                    output out_width, output out_height, output last_pixel,
                    input ready);
    modport sink (input valid, input status, input dest_row, input dest_col,
                  input red, input green, input blue, input alpha,
                  input out_width, input out_height, input last_pixel,
                  output ready);
endinterface

interface dib_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dib_pkg::CFG_IDX_W-1:0]  index;
    logic [31:0]                    wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

/* sv/dib_to_rgba_converter_core.sv */
// ============================================================================
// DIB to RGBA converter
// Turns the stored pixel bytes of a 24- or 32-bit bitmap into RGBA pixels
// carrying their top-down row and column.
// ============================================================================
// i_byte takes one pixel-data byte per cycle in stored order while ready is
// high. o_pix gives one word per completed pixel, or one error word per byte
// when the header registers fail their checks; padding and trailing bytes
// give nothing. i_cfg writes the header registers and is always ready; any
// write to a listed register restarts the image at its first byte.
// The word for an accepted byte is written into the result buffer at the edge
// that accepts it, so while i_byte.ready is high the throughput is one byte
// per cycle, set by the single step between the byte and the result register.
// The header check takes two registered stages, so after reset and after every
// register write i_byte.ready is low until r_settle counts down to zero.
// Reset restores the default header and clears the stream position.
// A two-word result buffer absorbs receiver stalls; once it holds two words,
// i_byte.ready drops until the receiver takes one.
// ============================================================================
module dib_to_rgba_converter_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dib_byte_if.sink  i_byte,
    dib_cfg_if.sink   i_cfg,
    dib_pix_if.source o_pix
);
    import dib_pkg::*;

    t_cfg        r_cfg;
    t_hdr        w_hdr;
    logic [1:0]  r_settle;

    logic [1:0]  r_byte_in_pixel, n_byte_in_pixel;
    logic [1:0]  r_pad_left, n_pad_left;
    logic [14:0] r_column_count, n_column_count;
    logic [14:0] r_stored_row, n_stored_row;
    logic [7:0]  r_held_blue, n_held_blue;
    logic [7:0]  r_held_green, n_held_green;
    logic [7:0]  r_held_red, n_held_red;
    logic        r_image_done, n_image_done;

    logic        w_cfg_wr;
    logic        w_in_acc;
    logic        w_room;
    logic        w_push;
    logic        w_col_last;
    logic        w_row_last;
    t_pix        w_pix;
    t_pix        w_head;

    assign w_cfg_wr     = i_cfg.valid && i_cfg.ready && (i_cfg.index <= CFG_AVAILABLE);
    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = (r_settle == 2'd0) && w_room;
    assign w_in_acc     = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_size      <= MIN_HEADER_SIZE;
            r_cfg.image_width      <= 16'sd1;
            r_cfg.image_height     <= 16'sd1;
            r_cfg.bits_per_pixel   <= BPP_32;
            r_cfg.compression_kind <= COMP_RGB;
            r_cfg.available_bytes  <= 32'd0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg.index)
                CFG_HEADER_SIZE:    r_cfg.header_size      <= i_cfg.wdata[15:0];
                CFG_IMAGE_WIDTH:    r_cfg.image_width      <= i_cfg.wdata[15:0];
                CFG_IMAGE_HEIGHT:   r_cfg.image_height     <= i_cfg.wdata[15:0];
                CFG_BITS_PER_PIXEL: r_cfg.bits_per_pixel   <= i_cfg.wdata[15:0];
                CFG_COMPRESSION:    r_cfg.compression_kind <= i_cfg.wdata[3:0];
                default:            r_cfg.available_bytes  <= i_cfg.wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= 2'd2;
        end else if (w_cfg_wr) begin
            r_settle <= 2'd2;
        end else if (r_settle != 2'd0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    dib_hdr_chk u_hdr_chk (
        .i_clk (i_clk),
        .i_cfg (r_cfg),
        .o_hdr (w_hdr)
    );

    assign w_col_last = ({1'b0, r_column_count} + 16'd1) >= {1'b0, w_hdr.width};
    assign w_row_last = ({1'b0, r_stored_row} + 16'd1) >= {1'b0, w_hdr.height};

    always_comb begin
        n_byte_in_pixel = r_byte_in_pixel;
        n_pad_left      = r_pad_left;
        n_column_count  = r_column_count;
        n_stored_row    = r_stored_row;
        n_held_blue     = r_held_blue;
        n_held_green    = r_held_green;
        n_held_red      = r_held_red;
        n_image_done    = r_image_done;
        w_push          = 1'b0;
        w_pix           = '0;
        if (w_cfg_wr) begin
            n_byte_in_pixel = 2'd0;
            n_pad_left      = 2'd0;
            n_column_count  = 15'd0;
            n_stored_row    = 15'd0;
            n_held_blue     = 8'd0;
            n_held_green    = 8'd0;
            n_held_red      = 8'd0;
            n_image_done    = 1'b0;
        end else if (w_in_acc) begin
            if (w_hdr.status != ST_OK) begin
                w_push       = 1'b1;
                w_pix.status = w_hdr.status;
            end else if (r_image_done) begin
                w_push = 1'b0;
            end else if (r_pad_left != 2'd0) begin
                n_pad_left = r_pad_left - 2'd1;
                if (r_pad_left == 2'd1) begin
                    n_stored_row = r_stored_row + 15'd1;
                end
            end else if (r_byte_in_pixel < (w_hdr.bpp32 ? 2'd3 : 2'd2)) begin
                unique case (r_byte_in_pixel)
                    2'd0:    n_held_blue  = i_byte.data_byte;
                    2'd1:    n_held_green = i_byte.data_byte;
                    default: n_held_red   = i_byte.data_byte;
                endcase
                n_byte_in_pixel = r_byte_in_pixel + 2'd1;
            end else begin
                w_push           = 1'b1;
                n_byte_in_pixel  = 2'd0;
                w_pix.status     = ST_OK;
                w_pix.dest_col   = r_column_count;
                w_pix.green      = r_held_green;
                w_pix.blue       = r_held_blue;
                w_pix.out_width  = w_hdr.width;
                w_pix.out_height = w_hdr.height;
                w_pix.last_pixel = w_row_last && w_col_last;
                if (w_hdr.bpp32) begin
                    w_pix.red   = r_held_red;
                    w_pix.alpha = i_byte.data_byte;
                end else begin
                    w_pix.red   = i_byte.data_byte;
                    w_pix.alpha = OPAQUE_ALPHA;
                    n_held_red  = i_byte.data_byte;
                end
                if (!w_hdr.rows_reversed) begin
                    w_pix.dest_row = r_stored_row;
                end else if (r_stored_row < w_hdr.height) begin
                    w_pix.dest_row = w_hdr.height - 15'd1 - r_stored_row;
                end else begin
                    w_pix.dest_row = 15'd0;
                end
                if (w_row_last && w_col_last) begin
                    n_image_done = 1'b1;
                end else if (w_col_last) begin
                    n_column_count = 15'd0;
                    if (w_hdr.pad != 2'd0) begin
                        n_pad_left = w_hdr.pad;
                    end else begin
                        n_stored_row = r_stored_row + 15'd1;
                    end
                end else begin
                    n_column_count = r_column_count + 15'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_in_pixel <= 2'd0;
            r_pad_left      <= 2'd0;
            r_column_count  <= 15'd0;
            r_stored_row    <= 15'd0;
            r_held_blue     <= 8'd0;
            r_held_green    <= 8'd0;
            r_held_red      <= 8'd0;
            r_image_done    <= 1'b0;
        end else begin
            r_byte_in_pixel <= n_byte_in_pixel;
            r_pad_left      <= n_pad_left;
            r_column_count  <= n_column_count;
            r_stored_row    <= n_stored_row;
            r_held_blue     <= n_held_blue;
            r_held_green    <= n_held_green;
            r_held_red      <= n_held_red;
            r_image_done    <= n_image_done;
        end
    end

    dib_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_pix),
        .o_room  (w_room),
        .o_valid (o_pix.valid),
        .i_ready (o_pix.ready),
        .o_word  (w_head)
    );

    assign o_pix.status     = w_head.status;
    assign o_pix.dest_row   = w_head.dest_row;
    assign o_pix.dest_col   = w_head.dest_col;
    assign o_pix.red        = w_head.red;
    assign o_pix.green      = w_head.green;
    assign o_pix.blue       = w_head.blue;
    assign o_pix.alpha      = w_head.alpha;
    assign o_pix.out_width  = w_head.out_width;
    assign o_pix.out_height = w_head.out_height;
    assign o_pix.last_pixel = w_head.last_pixel;

    a_push_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_in_acc)
        else $error("result produced without an accepted byte");
    a_no_byte_settling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> (r_settle == 2'd0))
        else $error("byte accepted while the header check settles");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_pix.last_pixel && !w_cfg_wr) |=> r_image_done)
        else $error("image not closed after its last pixel");
    a_pad_only_24: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad_left != 2'd0) |-> (r_byte_in_pixel == 2'd0))
        else $error("row padding in the middle of a pixel");

endmodule

/* sv/dib_hdr_chk.sv */
// ============================================================================
// DIB header check
// Two registered stages that validate the header registers and derive the
// image geometry: field checks and stride product, then the size compare.
// ============================================================================
module dib_hdr_chk (
    input  logic          i_clk,
    input  dib_pkg::t_cfg i_cfg,
    output dib_pkg::t_hdr o_hdr
);
    import dib_pkg::*;

    logic        n_fail;
    logic [14:0] n_width;
    logic [14:0] n_height;
    logic [16:0] n_stride;
    logic [16:0] w_w3;
    logic        n_bpp32;

    logic        r_fail;
    logic [31:0] r_need;
    logic [31:0] r_avail;
    logic [14:0] r_width;
    logic [14:0] r_height;
    logic        r_rows_reversed;
    logic        r_bpp32;
    t_hdr        r_hdr;

    always_comb begin
        n_bpp32  = (i_cfg.bits_per_pixel == BPP_32);
        n_fail   = 1'b0;
        if (i_cfg.header_size < MIN_HEADER_SIZE) begin
            n_fail = 1'b1;
        end
        if (i_cfg.image_width[15] || (i_cfg.image_width == 16'sd0)) begin
            n_fail = 1'b1;
        end
        if ((i_cfg.image_height == 16'sd0) || (i_cfg.image_height == 16'sh8000)) begin
            n_fail = 1'b1;
        end
        if ((i_cfg.bits_per_pixel != BPP_24) && !n_bpp32) begin
            n_fail = 1'b1;
        end
        if ((i_cfg.compression_kind != COMP_RGB)
                && (i_cfg.compression_kind != COMP_BITFIELDS)) begin
            n_fail = 1'b1;
        end
        if ((i_cfg.compression_kind == COMP_BITFIELDS) && !n_bpp32) begin
            n_fail = 1'b1;
        end
        n_width  = i_cfg.image_width[14:0];
        n_height = i_cfg.image_height[15] ? 15'(-i_cfg.image_height)
                                          : i_cfg.image_height[14:0];
        w_w3     = {2'b00, n_width} + {1'b0, n_width, 1'b0} + 17'd3;
        n_stride = n_bpp32 ? {n_width, 2'b00} : {w_w3[16:2], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        r_fail          <= n_fail;
        r_need          <= 32'(n_stride * n_height);
        r_avail         <= i_cfg.available_bytes;
        r_width         <= n_width;
        r_height        <= n_height;
        r_rows_reversed <= !i_cfg.image_height[15];
        r_bpp32         <= n_bpp32;
    end

    always_ff @(posedge i_clk) begin
        if (r_fail) begin
            r_hdr.status <= ST_HDR_REJECT;
        end else if (r_avail < r_need) begin
            r_hdr.status <= ST_TOO_SHORT;
        end else begin
            r_hdr.status <= ST_OK;
        end
        r_hdr.width         <= r_width;
        r_hdr.height        <= r_height;
        r_hdr.rows_reversed <= r_rows_reversed;
        r_hdr.bpp32         <= r_bpp32;
        r_hdr.pad           <= r_bpp32 ? 2'd0 : r_width[1:0];
    end

    assign o_hdr = r_hdr;

endmodule

/* sv/dib_out_buf.sv */
// ============================================================================
// DIB result buffer
// Two-word output buffer that lets the converter keep taking bytes while a
// finished pixel waits for the receiver.
// ============================================================================
module dib_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dib_pkg::t_pix i_word,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_ready,
    output dib_pkg::t_pix o_word
);
    import dib_pkg::*;

    t_pix       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_room  = (r_cnt != 2'd2);
    assign o_word  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(w_pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !i_push)
        else $error("result pushed into a full buffer");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wr != r_rd))
        else $error("buffer pointers disagree with count");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// DIB to RGBA converter testbench
// Writes header registers between images, streams pixel bytes through the
// converter with random gaps and receiver stalls, and checks every result
// word against a predictor kept in step with each accepted byte.
// ============================================================================
module tb_top;
    import dib_pkg::*;

    localparam int unsigned RANDOM_BYTES = 400;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 byte_valid = 1'b0;
    logic [7:0]           byte_data  = 8'd0;
    logic                 cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = CFG_HEADER_SIZE;
    logic [31:0]          cfg_wdata  = 32'd0;
    logic                 pix_ready  = 1'b0;

    dib_byte_if byte_if ();
    dib_cfg_if  cfg_if ();
    dib_pix_if  pix_if ();

    assign byte_if.valid     = byte_valid;
    assign byte_if.data_byte = byte_data;
    assign cfg_if.valid      = cfg_valid;
    assign cfg_if.index      = cfg_index;
    assign cfg_if.wdata      = cfg_wdata;
    assign pix_if.ready      = pix_ready;

    dib_to_rgba_converter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .i_cfg   (cfg_if),
        .o_pix   (pix_if)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: header registers and stream position.
    t_cfg        hdr_regs;
    logic [1:0]  byte_in_pixel = '0;
    logic [1:0]  pad_left      = '0;
    logic [14:0] column_count  = '0;
    logic [14:0] stored_row    = '0;
    logic [7:0]  held_blue     = '0;
    logic [7:0]  held_green    = '0;
    logic [7:0]  held_red      = '0;
    logic        image_done    = 1'b0;

    logic [7:0]  pending_bytes[$];
    t_pix        expected_pixels[$];

    int unsigned error_count    = 0;
    int unsigned words_seen     = 0;
    int unsigned bytes_accepted = 0;
    int unsigned cycle_count    = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;
    bit          calm_src       = 1'b0;
    bit          calm_snk       = 1'b0;

    function automatic int unsigned idle_len(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [1:0] header_check(output int unsigned w, output int unsigned h);
        int                wd;
        int                ht;
        int unsigned       nbytes;
        longint unsigned   stride;
        wd = $signed(hdr_regs.image_width);
        ht = $signed(hdr_regs.image_height);
        w  = 0;
        h  = 0;
        if (hdr_regs.header_size < MIN_HEADER_SIZE) return ST_HDR_REJECT;
        if (wd <= 0) return ST_HDR_REJECT;
        if (ht == 0 || ht < -32767) return ST_HDR_REJECT;
        if (hdr_regs.bits_per_pixel != BPP_24 && hdr_regs.bits_per_pixel != BPP_32)
            return ST_HDR_REJECT;
        if (hdr_regs.compression_kind != COMP_RGB
                && hdr_regs.compression_kind != COMP_BITFIELDS)
            return ST_HDR_REJECT;
        if (hdr_regs.compression_kind == COMP_BITFIELDS && hdr_regs.bits_per_pixel != BPP_32)
            return ST_HDR_REJECT;
        w      = wd;
        h      = (ht > 0) ? ht : -ht;
        nbytes = (hdr_regs.bits_per_pixel == BPP_24) ? 3 : 4;
        stride = ((longint'(w) * nbytes + 3) / 4) * 4;
        if ({32'd0, hdr_regs.available_bytes} < stride * h) return ST_TOO_SHORT;
        return ST_OK;
    endfunction

    // Advances the stream by one byte; returns 1 when the byte yields a word.
    function automatic bit convert_byte(input logic [7:0] b, output t_pix px);
        int unsigned w;
        int unsigned h;
        int unsigned nbytes;
        int unsigned pad;
        logic [1:0]  st;
        bit          last;
        px = '0;
        st = header_check(w, h);
        if (st != ST_OK) begin
            px.status = st;
            return 1'b1;
        end
        if (image_done) return 1'b0;
        if (pad_left != 0) begin
            pad_left = pad_left - 2'd1;
            if (pad_left == 0) stored_row = stored_row + 15'd1;
            return 1'b0;
        end
        nbytes = (hdr_regs.bits_per_pixel == BPP_24) ? 3 : 4;
        if (byte_in_pixel + 1 < nbytes) begin
            case (byte_in_pixel)
                2'd0: held_blue = b;
                2'd1: held_green = b;
                default: held_red = b;
            endcase
            byte_in_pixel = byte_in_pixel + 2'd1;
            return 1'b0;
        end
        if (nbytes == 3) begin
            held_red = b;
            px.alpha = OPAQUE_ALPHA;
        end else begin
            px.alpha = b;
        end
        byte_in_pixel = 2'd0;
        last = (stored_row + 1 >= h) && (column_count + 1 >= w);
        px.status = ST_OK;
        if ($signed(hdr_regs.image_height) > 0)
            px.dest_row = (stored_row < h) ? 15'(h - 1 - stored_row) : 15'd0;
        else
            px.dest_row = stored_row;
        px.dest_col   = column_count;
        px.red        = held_red;
        px.green      = held_green;
        px.blue       = held_blue;
        px.out_width  = 15'(w);
        px.out_height = 15'(h);
        px.last_pixel = last;
        if (last) begin
            image_done = 1'b1;
            return 1'b1;
        end
        if (column_count + 1 >= w) begin
            pad          = (4 - ((w * nbytes) & 3)) & 3;
            column_count = '0;
            if (pad != 0) pad_left = 2'(pad);
            else stored_row = stored_row + 15'd1;
        end else begin
            column_count = column_count + 15'd1;
        end
        return 1'b1;
    endfunction

    task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("tb_top: mismatch on %s at word %0d: got %0h, want %0h",
                 what, words_seen, got, want);
        error_count++;
    endtask

    task automatic compare_word(input t_pix got, input t_pix want);
        if (got.status !== want.status) flag("status", got.status, want.status);
        if (got.dest_row !== want.dest_row) flag("dest_row", got.dest_row, want.dest_row);
        if (got.dest_col !== want.dest_col) flag("dest_col", got.dest_col, want.dest_col);
        if (got.red !== want.red) flag("red", got.red, want.red);
        if (got.green !== want.green) flag("green", got.green, want.green);
        if (got.blue !== want.blue) flag("blue", got.blue, want.blue);
        if (got.alpha !== want.alpha) flag("alpha", got.alpha, want.alpha);
        if (got.out_width !== want.out_width) flag("out_width", got.out_width, want.out_width);
        if (got.out_height !== want.out_height)
            flag("out_height", got.out_height, want.out_height);
        if (got.last_pixel !== want.last_pixel)
            flag("last_pixel", got.last_pixel, want.last_pixel);
    endtask

    // Byte sender.
    always @(posedge i_clk) begin : byte_sender
        t_pix        word;
        int unsigned send_gap;
        if (i_rst_n) begin
            if (byte_valid && byte_if.ready) begin
                if (convert_byte(byte_data, word)) expected_pixels.push_back(word);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (!byte_valid || byte_if.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    byte_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    byte_data  <= pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                    send_gap = idle_len(calm_src);
                end else begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once a big burst is queued, so the input stalls.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_accepted >= 30 && pending_bytes.size() >= 12) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Pixel receiver and checker.
    always @(posedge i_clk) begin : pixel_sink
        t_pix        seen;
        int unsigned sink_stall;
        if (i_rst_n) begin
            if (pix_if.valid && pix_ready) begin
                seen.status     = pix_if.status;
                seen.dest_row   = pix_if.dest_row;
                seen.dest_col   = pix_if.dest_col;
                seen.red        = pix_if.red;
                seen.green      = pix_if.green;
                seen.blue       = pix_if.blue;
                seen.alpha      = pix_if.alpha;
                seen.out_width  = pix_if.out_width;
                seen.out_height = pix_if.out_height;
                seen.last_pixel = pix_if.last_pixel;
                if (expected_pixels.size() == 0) flag("unexpected word", seen.status, '0);
                else compare_word(seen, expected_pixels.pop_front());
                words_seen++;
            end
            if (hold_left != 0) begin
                pix_ready <= 1'b0;
            end else if (sink_stall != 0) begin
                sink_stall--;
                pix_ready <= 1'b0;
            end else begin
                pix_ready <= 1'b1;
                sink_stall = idle_len(calm_snk);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_HEADER_SIZE:    hdr_regs.header_size      = val[15:0];
            CFG_IMAGE_WIDTH:    hdr_regs.image_width      = val[15:0];
            CFG_IMAGE_HEIGHT:   hdr_regs.image_height     = val[15:0];
            CFG_BITS_PER_PIXEL: hdr_regs.bits_per_pixel   = val[15:0];
            CFG_COMPRESSION:    hdr_regs.compression_kind = val[3:0];
            CFG_AVAILABLE:      hdr_regs.available_bytes  = val;
            default: ;
        endcase
        if (idx <= CFG_AVAILABLE) begin
            byte_in_pixel = '0;
            pad_left      = '0;
            column_count  = '0;
            stored_row    = '0;
            held_blue     = '0;
            held_green    = '0;
            held_red      = '0;
            image_done    = 1'b0;
        end
    endtask

    // Writes all six registers in rotated order; bits above each field are junk.
    task automatic set_header(input logic [15:0] hs, input logic [15:0] wd,
                              input logic [15:0] ht, input logic [15:0] bpp,
                              input logic [3:0] comp, input logic [31:0] avail,
                              input bit stray);
        logic [CFG_IDX_W-1:0] regs [6];
        logic [31:0]          vals [6];
        logic [31:0]          r;
        int                   first;
        r       = $urandom();
        regs[0] = CFG_HEADER_SIZE;
        regs[1] = CFG_IMAGE_WIDTH;
        regs[2] = CFG_IMAGE_HEIGHT;
        regs[3] = CFG_BITS_PER_PIXEL;
        regs[4] = CFG_COMPRESSION;
        regs[5] = CFG_AVAILABLE;
        vals[0] = {r[31:16], hs};
        vals[1] = {r[15:0], wd};
        vals[2] = {r[23:8], ht};
        vals[3] = {r[7:0], r[31:24], bpp};
        vals[4] = {r[31:4], comp};
        vals[5] = avail;
        first   = $urandom_range(0, 5);
        for (int k = 0; k < 6; k++) begin
            if (stray && k == 3) write_reg(CFG_AVAILABLE + 3'($urandom_range(1, 2)), $urandom());
            write_reg(regs[(first + k) % 6], vals[(first + k) % 6]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || byte_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic feed(input int n);
        for (int k = 0; k < n; k++) pending_bytes.push_back(8'($urandom()));
        wait_idle();
    endtask

    task automatic random_image(output int counted);
        int          w;
        int          h;
        int          nb;
        int          need;
        int          n_bytes;
        int          kind;
        logic [15:0] hs;
        logic [15:0] bpp;
        logic [3:0]  comp;
        logic [31:0] avail;
        w    = $urandom_range(1, 5);
        h    = $urandom_range(1, 4);
        if ($urandom_range(0, 1)) h = -h;
        nb   = $urandom_range(3, 4);
        bpp  = (nb == 3) ? BPP_24 : BPP_32;
        comp = (nb == 4 && $urandom_range(0, 1)) ? COMP_BITFIELDS : COMP_RGB;
        hs   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(40, 65535)) : MIN_HEADER_SIZE;
        need = ((w * nb + 3) / 4) * 4 * ((h < 0) ? -h : h);
        avail = need + $urandom_range(0, 3) * $urandom_range(0, 50);
        if ($urandom_range(0, 4) == 0) n_bytes = $urandom_range(1, need);
        else n_bytes = need + $urandom_range(0, 6);
        kind = $urandom_range(0, 13);
        case (kind)
            0: hs = ($urandom_range(0, 1)) ? 16'd0 : 16'($urandom_range(1, 39));
            1: w = ($urandom_range(0, 1)) ? 0 : -$urandom_range(1, 32768);
            2: h = ($urandom_range(0, 1)) ? 0 : -32768;
            3: begin
                bpp = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 1) * 65535) : 16'($urandom());
                if (bpp == BPP_24 || bpp == BPP_32) bpp = 16'd8;
            end
            4: begin
                comp = 4'($urandom_range(1, 15));
                if (comp == COMP_BITFIELDS) comp = 4'd15;
            end
            5: begin
                bpp  = BPP_24;
                comp = COMP_BITFIELDS;
            end
            6: avail = $urandom_range(0, need - 1);
            7: begin
                if ($urandom_range(0, 1)) w = 32767;
                h     = ($urandom_range(0, 1)) ? 32767 : -32767;
                avail = '1;
            end
            default: ;
        endcase
        if (kind <= 7) n_bytes = $urandom_range(1, 8);
        calm_src = ($urandom_range(0, 4) == 0);
        calm_snk = ($urandom_range(0, 4) == 0);
        set_header(hs, 16'(w), 16'(h), bpp, comp, avail, $urandom_range(0, 3) == 0);
        feed(n_bytes);
        counted = (n_bytes > need) ? need : n_bytes;
    endtask

    initial begin
        int sent;
        int total;
        hdr_regs.header_size      = MIN_HEADER_SIZE;
        hdr_regs.image_width      = 16'd1;
        hdr_regs.image_height     = 16'd1;
        hdr_regs.bits_per_pixel   = BPP_32;
        hdr_regs.compression_kind = COMP_RGB;
        hdr_regs.available_bytes  = 32'd0;
        total = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset header with no data available: every byte reports data too short.
        feed(2);
        // Small bottom-up 24-bit image with row padding and trailing bytes.
        set_header(MIN_HEADER_SIZE, 16'd2, 16'd2, BPP_24, COMP_RGB, 32'd16, 1'b1);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        feed(16);
        // Every field at its rejecting extreme, including height of -32768.
        set_header(16'd0, 16'h8000, 16'h8000, 16'hFFFF, 4'hF, 32'd0, 1'b0);
        feed(1);
        // Widest top-down bitfields image that still fits.
        set_header(16'hFFFF, 16'h7FFF, 16'h8001, BPP_32, COMP_BITFIELDS, 32'hFFFF_FFFF, 1'b0);
        feed(4);

        while (total < RANDOM_BYTES) begin
            random_image(sent);
            total += sent;
        end
        wait_idle();
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule

/* filelist.f */
sv/dib_pkg.sv
sv/dib_ifs.sv
sv/dib_hdr_chk.sv
sv/dib_out_buf.sv
sv/dib_to_rgba_converter_core.sv
tb/tb_top.sv
